// ===== hdl/circular_queue_fifo_top_assert.svh =====
// ---------------------------------------------------------------------------
// circular_queue_fifo_top_assert.svh
// Assertion macros for the circular queue block. Empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_FIFO_TOP_ASSERT_SVH
`define CIRCULAR_QUEUE_FIFO_TOP_ASSERT_SVH

`ifndef SYNTH
// consequent must hold in the same cycle as the antecedent
`define CQF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cqf: same-cycle check failed");
// consequent must hold in the cycle after the antecedent
`define CQF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cqf: next-cycle check failed");
`else
`define CQF_ASSERT_SAME(label, clk, rst, ante, cons)
`define CQF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/cqf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cqf_pkg
// Shared widths, operation and status codes, and the command type.
// ---------------------------------------------------------------------------
package cqf_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 5;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_DISP = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_LISTED   = 3'd4
  } status_t;

  typedef struct packed {
    op_t                          op;
    logic signed [DATA_WIDTH-1:0] element;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

endpackage

// ===== hdl/cqf_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cqf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cqf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/cqf_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cqf_front
// Input side: takes items when the command queue has room and turns each
// known operation into a queued command. Unknown codes are dropped.
// ---------------------------------------------------------------------------
module cqf_front (
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [cqf_pkg::OP_W-1:0]              operation,
  input  logic signed [cqf_pkg::DATA_WIDTH-1:0] element,
  input  logic                                  q_full,
  output cqf_pkg::push_t                        push
);
  import cqf_pkg::*;

  logic take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    push.valid       = 1'b0;
    push.cmd.op      = OP_ENQ;
    push.cmd.element = element;
    unique case (operation)
      OP_ENQ: begin
        push.valid  = take;
        push.cmd.op = OP_ENQ;
      end
      OP_DEQ: begin
        push.valid  = take;
        push.cmd.op = OP_DEQ;
      end
      OP_DISP: begin
        push.valid  = take;
        push.cmd.op = OP_DISP;
      end
      default: begin
        push.valid = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/cqf_cmdq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cqf_cmdq
// Two-entry command queue between the front and back halves.
// ---------------------------------------------------------------------------
module cqf_cmdq (
  input  logic            clk,
  input  logic            rst,
  input  cqf_pkg::push_t  push,
  input  logic            pop,
  output logic            full,
  output logic            cmd_valid,
  output cqf_pkg::cmd_t   cmd
);
  import cqf_pkg::*;

  cmd_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = entry[rptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push.cmd;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/cqf_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cqf_back
// Execution side: owns head, tail, count and the slot RAM, runs each
// command and drives the registered result port.
// ---------------------------------------------------------------------------
module cqf_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [cqf_pkg::CAP_W-1:0]             cfg_wdata,
  input  logic                                  cmd_valid,
  input  cqf_pkg::cmd_t                         cmd,
  output logic                                  cmd_pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output cqf_pkg::status_t                      out_status,
  output logic signed [cqf_pkg::DATA_WIDTH-1:0] out_value,
  output logic                                  out_last
);
  import cqf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_LIST
  } state_t;

  state_t                state, state_next;
  logic [CNT_W-1:0]      cap, cap_next;
  logic [ADDR_W-1:0]     head, head_next;
  logic [ADDR_W-1:0]     tail, tail_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [ADDR_W-1:0]     idx, idx_next;
  logic [CNT_W-1:0]      k, k_next;
  logic                  out_valid_next;
  status_t               out_status_next;
  logic [DATA_WIDTH-1:0] out_value_next;
  logic                  out_last_next;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  out_free;
  logic                  k_last;

  // wrap at the configured capacity, not the built depth
  function automatic logic [ADDR_W-1:0] adv(input logic [ADDR_W-1:0] i,
                                            input logic [CNT_W-1:0]  c);
    logic [CNT_W-1:0] n;
    n = CNT_W'(i) + CNT_W'(1);
    return (n >= c) ? '0 : n[ADDR_W-1:0];
  endfunction

  cqf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || !out_stall;
  assign k_last   = ((k + CNT_W'(1)) == count);

  always_comb begin
    state_next      = state;
    cap_next        = cap;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    idx_next        = idx;
    k_next          = k;
    out_valid_next  = out_valid && out_stall;
    out_status_next = out_status;
    out_value_next  = out_value;
    out_last_next   = out_last;
    ram_we          = 1'b0;
    ram_waddr       = tail;
    ram_wdata       = cmd.element;
    ram_re          = 1'b0;
    ram_raddr       = head;
    cmd_pop         = 1'b0;

    if (cfg_wen) begin
      if (cfg_wdata == '0) begin
        cap_next = CNT_W'(1);
      end else if (int'(cfg_wdata) > DEPTH) begin
        cap_next = CNT_W'(DEPTH);
      end else begin
        cap_next = CNT_W'(cfg_wdata);
      end
      head_next  = '0;
      tail_next  = '0;
      count_next = '0;
      state_next = S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && out_free) begin
            cmd_pop = 1'b1;
            case (cmd.op)
              OP_ENQ: begin
                out_valid_next = 1'b1;
                out_last_next  = 1'b1;
                if (count >= cap) begin
                  out_status_next = ST_FULL;
                  out_value_next  = '0;
                end else begin
                  ram_we          = 1'b1;
                  tail_next       = adv(tail, cap);
                  count_next      = count + CNT_W'(1);
                  out_status_next = ST_INSERTED;
                  out_value_next  = cmd.element;
                end
              end
              OP_DEQ, OP_DISP: begin
                if (count == '0) begin
                  out_valid_next  = 1'b1;
                  out_last_next   = 1'b1;
                  out_status_next = ST_EMPTY;
                  out_value_next  = '0;
                end else begin
                  ram_re     = 1'b1;
                  idx_next   = head;
                  k_next     = '0;
                  state_next = (cmd.op == OP_DEQ) ? S_DEQ : S_LIST;
                end
              end
              default: begin
                cmd_pop = 1'b1;
              end
            endcase
          end
        end
        S_DEQ: begin
          if (out_free) begin
            out_valid_next  = 1'b1;
            out_last_next   = 1'b1;
            out_status_next = ST_REMOVED;
            out_value_next  = ram_rdata;
            count_next      = count - CNT_W'(1);
            // taking the last element rewinds both pointers
            if (count == CNT_W'(1)) begin
              head_next = '0;
              tail_next = '0;
            end else begin
              head_next = adv(head, cap);
            end
            state_next = S_IDLE;
          end
        end
        S_LIST: begin
          if (out_free) begin
            out_valid_next  = 1'b1;
            out_last_next   = k_last;
            out_status_next = ST_LISTED;
            out_value_next  = ram_rdata;
            if (k_last) begin
              state_next = S_IDLE;
            end else begin
              // fetch the next slot while this one is shown
              ram_re    = 1'b1;
              ram_raddr = adv(idx, cap);
              idx_next  = adv(idx, cap);
              k_next    = k + CNT_W'(1);
            end
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_value  <= out_value_next;
    out_last   <= out_last_next;
    idx        <= idx_next;
    k          <= k_next;
    if (rst) begin
      state     <= S_IDLE;
      cap       <= CNT_W'(DEPTH);
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cap       <= cap_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hdl/circular_queue_fifo_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circular_queue_fifo_top
// Ring-buffer queue of up to 16 signed 32-bit values with a settable capacity.
//
// Input channel: in_valid/in_stall with operation and element. Operation 0
// enqueues element, 1 dequeues the oldest value, 2 lists every stored value
// oldest first; code 3 is taken and dropped. Output channel: out_valid/
// out_stall with status, value and last; last marks an item's final result.
// Capacity is written through cfg_wen/cfg_wdata; the user must write it only
// while idle, since the block does not enforce this. A write empties the
// queue, 0 acts as 1 and values above 16 act as 16. Enqueues and full/empty
// answers pass through the command queue to the result register; dequeue
// and listing also pass the registered read port of the slot RAM.
// Sustained rate: one enqueue per cycle while out_stall is low.
// Reset (rst, synchronous) empties the queue and sets capacity to 16.
// When out_stall is high with out_valid set, the result register holds; the
// 2-entry command queue keeps taking items until it fills, then in_stall rises.
// ---------------------------------------------------------------------------
`include "circular_queue_fifo_top_assert.svh"

module circular_queue_fifo_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [cqf_pkg::CAP_W-1:0]             cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [cqf_pkg::OP_W-1:0]              operation,
  input  logic signed [cqf_pkg::DATA_WIDTH-1:0] element,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [cqf_pkg::STATUS_W-1:0]          status,
  output logic signed [cqf_pkg::DATA_WIDTH-1:0] value,
  output logic                                  last
);
  import cqf_pkg::*;

  push_t   q_push;
  logic    q_full;
  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  status_t out_status;

  cqf_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .element   (element),
    .q_full    (q_full),
    .push      (q_push)
  );

  cqf_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .pop       (cmd_pop),
    .full      (q_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  cqf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_value  (value),
    .out_last   (last)
  );

  assign status = out_status;

  `CQF_ASSERT_SAME(a_single_is_last, clk, rst, out_valid && (out_status != ST_LISTED), last)
  `CQF_ASSERT_SAME(a_zero_on_miss, clk, rst, out_valid && ((out_status == ST_FULL) || (out_status == ST_EMPTY)), value == '0)
  `CQF_ASSERT_SAME(a_drop_unknown, clk, rst, in_valid && !in_stall && (operation == 2'd3), !q_push.valid)
  `CQF_ASSERT_NEXT(a_push_lands, clk, rst, q_push.valid && !q_full, cmd_valid)

endmodule

// ===== tb/sv/circular_queue_fifo_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circular_queue_fifo_top_tb
// Self-checking bench for the ring-buffer queue. A scoreboard mirrors the
// queue (slots, head, tail, count, capacity) and predicts every result of
// each accepted item. Directed items hit the empty, full and extreme-value
// cases, then random phases run at several capacities with random stalls on
// both channels, one long output hold-off and a final stretch at full rate.
// ---------------------------------------------------------------------------
import cqf_pkg::*;

typedef struct {
  status_t               status;
  logic [DATA_WIDTH-1:0] value;
  logic                  last;
} queue_result_t;

class cqf_scoreboard;
  queue_result_t         expected_results[$];
  logic [DATA_WIDTH-1:0] mirror_slots[DEPTH];
  int unsigned           head;
  int unsigned           tail;
  int unsigned           count;
  int unsigned           capacity;
  int unsigned           errors;

  function new();
    head     = 0;
    tail     = 0;
    count    = 0;
    capacity = DEPTH;
    errors   = 0;
  endfunction

  // A capacity write empties the queue.
  function void write_capacity(logic [CAP_W-1:0] cap);
    capacity = cap;
    head     = 0;
    tail     = 0;
    count    = 0;
  endfunction

  function int unsigned usable_slots();
    if (capacity == 0) return 1;
    if (capacity > DEPTH) return DEPTH;
    return capacity;
  endfunction

  function int unsigned next_slot(int unsigned idx);
    return (idx + 1 >= usable_slots()) ? 0 : idx + 1;
  endfunction

  function void push_result(status_t st, logic [DATA_WIDTH-1:0] val, logic lst);
    queue_result_t r;
    r.status = st;
    r.value  = val;
    r.last   = lst;
    expected_results.push_back(r);
  endfunction

  function void accept_cmd(logic [OP_W-1:0] op, logic [DATA_WIDTH-1:0] elem);
    int unsigned idx;
    logic [DATA_WIDTH-1:0] taken;
    case (op)
      OP_ENQ: begin
        if (count >= usable_slots()) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          mirror_slots[tail] = elem;
          tail = next_slot(tail);
          count++;
          push_result(ST_INSERTED, elem, 1'b1);
        end
      end
      OP_DEQ: begin
        if (count == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          taken = mirror_slots[head];
          count--;
          if (count == 0) begin
            head = 0;
            tail = 0;
          end else begin
            head = next_slot(head);
          end
          push_result(ST_REMOVED, taken, 1'b1);
        end
      end
      OP_DISP: begin
        if (count == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          idx = head;
          for (int unsigned k = 0; k < count; k++) begin
            push_result(ST_LISTED, mirror_slots[idx], (k + 1 == count));
            idx = next_slot(idx);
          end
        end
      end
      default: ; // code 3 is dropped without a result
    endcase
  endfunction

  task report(string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task check_result(logic [STATUS_W-1:0] st, logic [DATA_WIDTH-1:0] val,
                    logic lst);
    queue_result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("unexpected result status=%0d value=%h last=%b", st, val, lst));
      return;
    end
    want = expected_results.pop_front();
    if (st !== want.status)
      report($sformatf("status %0d, expected %0d", st, want.status));
    if (val !== want.value)
      report($sformatf("value %h, expected %h", val, want.value));
    if (lst !== want.last)
      report($sformatf("last %b, expected %b", lst, want.last));
  endtask

  function int pending();
    return expected_results.size();
  endfunction
endclass

module circular_queue_fifo_top_tb;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CAP_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       operation;
  logic [DATA_WIDTH-1:0] element;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [DATA_WIDTH-1:0] value;
  logic                  last;

  int          tx_idle_chance;
  int          rx_idle_chance;
  bit          hold_request;
  int unsigned cycle_count;

  cqf_scoreboard sb = new();

  circular_queue_fifo_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .element   (element),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .value     (value),
    .last      (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, value, last);
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    int rx_burst;
    rx_burst  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall    = 1'b0;
        hold_request = 1'b0;
      end else if (rx_burst > 0) begin
        out_stall = 1'b1;
        rx_burst--;
      end else begin
        out_stall = 1'b0;
        if (rx_idle_chance != 0 && $urandom_range(1, 100) <= rx_idle_chance)
          rx_burst = $urandom_range(1, 9);
      end
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [DATA_WIDTH-1:0] elem);
    @(negedge clk);
    in_valid  = 1'b1;
    operation = op;
    element   = elem;
    do @(posedge clk); while (in_stall);
    sb.accept_cmd(op, elem);
    if (tx_idle_chance != 0 && $urandom_range(1, 100) <= tx_idle_chance) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  endtask

  // Wait for every expected item, then allow for a trailing dropped command.
  task automatic drain_queue();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_queue();
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_wdata = cap;
    @(posedge clk);
    sb.write_capacity(cap);
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(logic [CAP_W-1:0] cap, int n_items, int enq_pct,
                              int idle_pct, bit long_hold);
    int r;
    logic [OP_W-1:0] op;
    write_capacity(cap);
    tx_idle_chance = idle_pct;
    rx_idle_chance = idle_pct;
    if (long_hold) hold_request = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(1, 100);
      if (r <= enq_pct)  op = OP_ENQ;
      else if (r <= 90)  op = OP_DEQ;
      else if (r <= 97)  op = OP_DISP;
      else               op = OP_NOP;
      send_item(op, pick_element());
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_wen        = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    operation      = OP_ENQ;
    element        = '0;
    tx_idle_chance = 0;
    rx_idle_chance = 0;
    hold_request   = 1'b0;
    cycle_count    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty queue at reset capacity, dropped code, extreme values
    send_item(OP_DEQ, '0);
    send_item(OP_DISP, '0);
    send_item(OP_NOP, '1);
    send_item(OP_ENQ, 32'h7FFF_FFFF);
    send_item(OP_ENQ, 32'h8000_0000);
    send_item(OP_ENQ, '0);
    send_item(OP_ENQ, '1);
    send_item(OP_ENQ, 32'h5555_5555);
    send_item(OP_ENQ, 32'hAAAA_AAAA);
    send_item(OP_DISP, '0);
    send_item(OP_DEQ, '0);
    send_item(OP_DEQ, '0);
    send_item(OP_NOP, '0);

    // capacity 0 behaves as one slot: full, then last element taken
    write_capacity('0);
    send_item(OP_ENQ, 32'h1234_5678);
    send_item(OP_ENQ, 32'h8765_4321);
    send_item(OP_DISP, '0);
    send_item(OP_DEQ, '0);
    send_item(OP_DEQ, '0);

    random_phase(5'd31, 40, 70, 20, 1'b0);
    random_phase(5'd3,  40, 50, 30, 1'b0);
    random_phase(5'd1,  30, 50, 0,  1'b0);
    random_phase(5'd16, 40, 75, 10, 1'b1);
    random_phase(5'd7,  40, 55, 40, 1'b0);
    random_phase(5'd17, 40, 60, 20, 1'b0);
    random_phase(5'd2,  30, 45, 20, 1'b0);
    random_phase(5'd16, 40, 60, 0,  1'b0);

    drain_queue();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cqf_pkg.sv
hdl/cqf_ram.sv
hdl/cqf_front.sv
hdl/cqf_cmdq.sv
hdl/cqf_back.sv
hdl/circular_queue_fifo_top.sv
tb/sv/circular_queue_fifo_top_tb.sv
